FILE: rtl/assert_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define DNP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define DNP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/dnp_pkg.sv
// Types and constants of the delta nibble PCM decoder.
package dnp_pkg;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned CntW         = IdxW + 1;
  localparam int unsigned SampleW      = 8;

  localparam logic [SampleW-1:0] SilenceLevel = 8'h80;

  // Delta pair fetched for one coded byte.
  typedef struct packed {
    logic               restart;
    logic [SampleW-1:0] delta_hi;
    logic [SampleW-1:0] delta_lo;
  } dnp_pair_t;

endpackage

FILE: rtl/dnp_if.sv
// Valid/ready channel interfaces for the decoder input bytes and output samples.
interface dnp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_start;

  modport source (output valid, output data_byte, output block_start, input ready);
  modport sink   (input valid, input data_byte, input block_start, output ready);
endinterface

interface dnp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pcm_sample;
  logic       pair_last;

  modport source (output valid, output pcm_sample, output pair_last, input ready);
  modport sink   (input valid, input pcm_sample, input pair_last, output ready);
endinterface

FILE: rtl/dnp_emit.sv
// Output stage: accumulates the running sample and emits two samples per coded byte.
`include "assert_macros.svh"

module dnp_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pair_vld_i,
  input  dnp_pkg::dnp_pair_t pair_i,
  output logic               pair_rdy_o,
  dnp_out_if.source          out_o
);
  import dnp_pkg::*;

  logic               out_vld_q, out_vld_d;
  logic [SampleW-1:0] out_sample_q, out_sample_d;
  logic               out_last_q, out_last_d;
  logic               lo_pend_q, lo_pend_d;
  logic [SampleW-1:0] lo_delta_q, lo_delta_d;
  logic [SampleW-1:0] run_q, run_d;
  logic [SampleW-1:0] base;
  logic [SampleW-1:0] sum_hi;
  logic [SampleW-1:0] sum_lo;
  logic               out_fire;
  logic               take;

  assign out_fire   = out_vld_q && out_o.ready;
  assign pair_rdy_o = !lo_pend_q && (!out_vld_q || out_o.ready);
  assign take       = pair_vld_i && pair_rdy_o;

  assign base   = pair_i.restart ? SilenceLevel : run_q;
  assign sum_hi = base + pair_i.delta_hi;
  assign sum_lo = run_q + lo_delta_q;

  always_comb begin
    out_vld_d    = out_vld_q;
    out_sample_d = out_sample_q;
    out_last_d   = out_last_q;
    lo_pend_d    = lo_pend_q;
    lo_delta_d   = lo_delta_q;
    run_d        = run_q;
    if (take) begin
      out_vld_d    = 1'b1;
      out_sample_d = sum_hi;
      out_last_d   = 1'b0;
      lo_pend_d    = 1'b1;
      lo_delta_d   = pair_i.delta_lo;
      run_d        = sum_hi;
    end else if (out_fire && lo_pend_q) begin
      out_sample_d = sum_lo;
      out_last_d   = 1'b1;
      lo_pend_d    = 1'b0;
      run_d        = sum_lo;
    end else if (out_fire) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      lo_pend_q <= 1'b0;
      run_q     <= SilenceLevel;
    end else begin
      out_vld_q <= out_vld_d;
      lo_pend_q <= lo_pend_d;
      run_q     <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_sample_q <= out_sample_d;
    out_last_q   <= out_last_d;
    lo_delta_q   <= lo_delta_d;
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.pcm_sample = out_sample_q;
  assign out_o.pair_last  = out_last_q;

  `DNP_ASSERT(a_pend_shows_hi, clk_i, rst_ni, !lo_pend_q || (out_vld_q && !out_last_q), "low sample pending without high sample shown")
  `DNP_ASSERT_NEXT(a_take_hi, clk_i, rst_ni, take, out_vld_q && !out_last_q && lo_pend_q, "pair taken but high sample not presented")
  `DNP_ASSERT_NEXT(a_hi_then_lo, clk_i, rst_ni, out_fire && lo_pend_q, out_vld_q && out_last_q && !lo_pend_q, "low sample did not follow high sample")

endmodule

FILE: rtl/delta_nibble_pcm_decoder.sv
// Top level of the 4-bit table-driven delta PCM decoder.
//
// The decoder takes one byte per input transaction. The first 16 bytes of a
// block (block_start high on the first) load the delta table and produce no
// output; every later byte yields two 8-bit unsigned samples, high nibble
// first, the second marked with pair_last. The running sample restarts at 128
// at each block. Bytes before the first block start load the table as if a
// block had begun. A coded byte occupies the output register for both of its
// samples, one after the other; the output stage takes the next coded byte
// only once the output is empty or its low sample is being accepted, so the
// single-sample output channel limits the coded-byte rate. A coded byte's
// first sample goes through the registered table read, then the accumulate.
// There is no clearing pass after reset.
`include "assert_macros.svh"

module delta_nibble_pcm_decoder (
  input  logic     clk_i,
  input  logic     rst_ni,
  dnp_in_if.sink   in_i,
  dnp_out_if.source out_o
);
  import dnp_pkg::*;

  // Table fill state: count of bytes loaded in this block, 0..16.
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] eff_cnt;
  logic            load;
  logic            in_fire;

  // Running-sample restart owed to the next coded byte.
  logic            restart_q, restart_d;

  // Delta table, one write port, two registered read ports.
  logic [SampleW-1:0] table_mem [TableEntries];

  // Read stage between table and output stage.
  logic            a_vld_q, a_vld_d;
  dnp_pair_t       a_pair_q;
  logic            a_take;

  logic [IdxW-1:0] hi_idx;
  logic [IdxW-1:0] lo_idx;

  assign eff_cnt = in_i.block_start ? '0 : fill_q;
  assign load    = !eff_cnt[IdxW];
  assign in_fire = in_i.valid && in_i.ready;
  assign hi_idx  = in_i.data_byte[7:4];
  assign lo_idx  = in_i.data_byte[3:0];

  assign in_i.ready = !a_vld_q || a_take;

  always_comb begin
    fill_d    = fill_q;
    restart_d = restart_q;
    a_vld_d   = a_vld_q;
    if (a_take) begin
      a_vld_d = 1'b0;
    end
    if (in_fire) begin
      if (load) begin
        fill_d = eff_cnt + CntW'(1);
        if (in_i.block_start) begin
          restart_d = 1'b1;
        end
      end else begin
        fill_d    = eff_cnt;
        restart_d = 1'b0;
        a_vld_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      restart_q <= 1'b0;
      a_vld_q   <= 1'b0;
    end else begin
      fill_q    <= fill_d;
      restart_q <= restart_d;
      a_vld_q   <= a_vld_d;
    end
  end

  // Table write on load bytes; both deltas read on coded bytes.
  always_ff @(posedge clk_i) begin
    if (in_fire && load) begin
      table_mem[eff_cnt[IdxW-1:0]] <= in_i.data_byte;
    end
    if (in_fire && !load) begin
      a_pair_q.restart  <= restart_q;
      a_pair_q.delta_hi <= table_mem[hi_idx];
      a_pair_q.delta_lo <= table_mem[lo_idx];
    end
  end

  dnp_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pair_vld_i (a_vld_q),
    .pair_i     (a_pair_q),
    .pair_rdy_o (a_take),
    .out_o      (out_o)
  );

  `DNP_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= CntW'(TableEntries), "table fill count beyond table size")
  `DNP_ASSERT_NEXT(a_coded_enters, clk_i, rst_ni, in_fire && !load, a_vld_q, "coded byte did not reach the read stage")
  `DNP_ASSERT_NEXT(a_start_restarts, clk_i, rst_ni, in_fire && in_i.block_start, restart_q && fill_q == CntW'(1), "block start did not restart the block")

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the delta nibble PCM decoder.
module tb;
  import dnp_pkg::*;

  localparam int unsigned DirectedLen    = 25;
  localparam int unsigned PhaseBytes     = 475;
  localparam int unsigned HoldoffCycles  = 300;
  localparam int unsigned WatchdogLimit  = 2000;
  localparam int unsigned TailCycles     = 8;
  localparam int unsigned MaxReported    = 10;
  localparam int unsigned TableLoadBytes = TableEntries - 1;  // after the start byte

  typedef struct packed {
    logic [SampleW-1:0] pcm_sample;
    logic               pair_last;
  } pcm_result_t;

  // One directed transaction. Where the samples are obvious from the table
  // they are typed in and used instead of the predicted ones.
  typedef struct packed {
    logic [7:0]         data;
    logic               start;
    logic               typed;
    logic [SampleW-1:0] want_hi;
    logic [SampleW-1:0] want_lo;
  } stim_row_t;

  // Table load without a block start (bytes before the first block start),
  // a few coded bytes, then a block start that cuts into a fresh table load.
  // Deltas: 00 01 FF 7F 80 10 F0 55 AA 02 FE 33 CC 0F F1 FF.
  localparam stim_row_t DirectedRows [DirectedLen] = '{
    '{8'h00, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'h01, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'h7F, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'h80, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'h10, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'hF0, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'h55, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'hAA, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'h02, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'hFE, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'h33, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'hCC, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'h0F, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'hF1, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'h00, 1'b0, 1'b1, 8'h80, 8'h80},  // zero delta: silence holds
    '{8'h12, 1'b0, 1'b1, 8'h81, 8'h80},  // +1 then -1
    '{8'h44, 1'b0, 1'b1, 8'h00, 8'h80},  // 0x80 + 0x80 wraps to zero
    '{8'hFF, 1'b0, 1'b1, 8'h7F, 8'h7E},  // top entry twice
    '{8'hF0, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'h3D, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'hA5, 1'b1, 1'b0, 8'h00, 8'h00},  // new block, entry 0
    '{8'h5A, 1'b0, 1'b0, 8'h00, 8'h00},
    '{8'hC3, 1'b0, 1'b0, 8'h00, 8'h00}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  dnp_in_if  byte_ch ();
  dnp_out_if sample_ch ();

  delta_nibble_pcm_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (sample_ch)
  );

  always #1 clk_i = ~clk_i;

  // Decoder shadow state.
  logic [SampleW-1:0] delta_lut [TableEntries] = '{default: '0};
  logic [CntW-1:0]    lut_fill = '0;
  logic [SampleW-1:0] level = SilenceLevel;

  pcm_result_t pending_samples [$];

  // Typed-in samples travel with the byte, stable while valid is high.
  logic               row_typed   = 1'b0;
  logic [SampleW-1:0] row_want_hi = '0;
  logic [SampleW-1:0] row_want_lo = '0;

  int unsigned src_idle_pct = 16;
  int unsigned snk_idle_pct = 69;
  int unsigned holdoff_req  = 0;
  int unsigned bytes_issued = 0;

  int unsigned bytes_taken     = 0;
  int unsigned samples_checked = 0;
  int unsigned block_starts    = 0;
  int unsigned cut_loads       = 0;
  int unsigned mismatches      = 0;
  int unsigned quiet_cycles    = 0;

  // Advances the shadow decoder by one byte; returns 1 when it yields samples.
  function automatic bit advance_decoder(input logic [7:0] b, input logic s,
                                         output logic [SampleW-1:0] hi_smp,
                                         output logic [SampleW-1:0] lo_smp);
    hi_smp = '0;
    lo_smp = '0;
    if (s) begin
      lut_fill = '0;
      level    = SilenceLevel;
    end
    if (lut_fill < TableEntries) begin
      delta_lut[lut_fill[IdxW-1:0]] = b;
      lut_fill = lut_fill + 1'b1;
      return 1'b0;
    end
    level  = level + delta_lut[b[7:4]];
    hi_smp = level;
    level  = level + delta_lut[b[3:0]];
    lo_smp = level;
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_delta();
    case ($urandom_range(15))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'h7F;
      3:       return 8'h80;
      4:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxReported) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Offers one byte and returns once its transaction has happened.
  task automatic send_byte(input logic [7:0] b, input logic s, input logic typed,
                           input logic [SampleW-1:0] want_hi,
                           input logic [SampleW-1:0] want_lo);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.data_byte   <= b;
    byte_ch.block_start <= s;
    row_typed           <= typed;
    row_want_hi         <= want_hi;
    row_want_lo         <= want_lo;
    bytes_issued++;
    do @(posedge clk_i); while (!byte_ch.ready);
  endtask

  task automatic send_random(input logic [7:0] b, input logic s);
    send_byte(b, s, 1'b0, '0, '0);
  endtask

  // Mostly complete blocks with random deltas and coded bytes; some table
  // loads cut short by the next block start, and some raw noise.
  task automatic random_traffic(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned run_len;
    stop_at = bytes_issued + n_bytes;
    while (bytes_issued < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 82) begin
        send_random(pick_delta(), 1'b1);
        repeat (TableLoadBytes) send_random(pick_delta(), 1'b0);
        run_len = ($urandom_range(9) == 0) ? $urandom_range(120, 40) : $urandom_range(24, 1);
        repeat (run_len) send_random(8'($urandom_range(255)), 1'b0);
      end else if (pick < 92) begin
        send_random(pick_delta(), 1'b1);
        repeat ($urandom_range(TableLoadBytes - 1)) send_random(pick_delta(), 1'b0);
      end else begin
        repeat ($urandom_range(12, 1))
          send_random(8'($urandom_range(255)), $urandom_range(9) == 0);
      end
    end
  endtask

  // Sender pauses until every predicted sample has been seen.
  task automatic drain();
    byte_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_samples.size() != 0);
  endtask

  // Receiver: random back-pressure, plus a long hold-off on request.
  initial begin : sample_sink
    int unsigned hold_left;
    int unsigned seen_req;
    hold_left = 0;
    seen_req  = 0;
    sample_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holdoff_req != seen_req) begin
        seen_req  = holdoff_req;
        hold_left = HoldoffCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        sample_ch.ready <= 1'b0;
      end else begin
        sample_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Output check first, then the input transaction of the same edge feeds the
  // predictor; one process keeps the queue order deterministic.
  always @(posedge clk_i) begin : transaction_monitor
    pcm_result_t        got;
    pcm_result_t        want;
    logic [SampleW-1:0] hi_smp;
    logic [SampleW-1:0] lo_smp;
    if (rst_ni) begin
      if (sample_ch.valid && sample_ch.ready) begin
        got.pcm_sample = sample_ch.pcm_sample;
        got.pair_last  = sample_ch.pair_last;
        samples_checked++;
        if (pending_samples.size() == 0) begin
          flag_mismatch($sformatf("unexpected sample %02h last %b",
                                  got.pcm_sample, got.pair_last));
        end else begin
          want = pending_samples.pop_front();
          if (got.pcm_sample !== want.pcm_sample || got.pair_last !== want.pair_last)
            flag_mismatch($sformatf("sample %02h last %b, expected sample %02h last %b",
                                    got.pcm_sample, got.pair_last,
                                    want.pcm_sample, want.pair_last));
        end
      end
      if (byte_ch.valid && byte_ch.ready) begin
        bytes_taken++;
        if (byte_ch.block_start) begin
          block_starts++;
          if (lut_fill != 0 && lut_fill < TableEntries) cut_loads++;
        end
        if (advance_decoder(byte_ch.data_byte, byte_ch.block_start, hi_smp, lo_smp)) begin
          want.pcm_sample = row_typed ? row_want_hi : hi_smp;
          want.pair_last  = 1'b0;
          pending_samples.push_back(want);
          want.pcm_sample = row_typed ? row_want_lo : lo_smp;
          want.pair_last  = 1'b1;
          pending_samples.push_back(want);
        end
      end
    end
  end

  // Ends a hung run: too many cycles with no transaction on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (byte_ch.valid && byte_ch.ready) || (sample_ch.valid && sample_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit - 1) begin
      $display("watchdog: no transaction in %0d cycles, %0d samples outstanding",
               WatchdogLimit, pending_samples.size());
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    byte_ch.valid       <= 1'b0;
    byte_ch.data_byte   <= '0;
    byte_ch.block_start <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender idles lightly, receiver heavily.
    for (int i = 0; i < DirectedLen; i++)
      send_byte(DirectedRows[i].data, DirectedRows[i].start, DirectedRows[i].typed,
                DirectedRows[i].want_hi, DirectedRows[i].want_lo);
    random_traffic(PhaseBytes);
    drain();

    // The other way round.
    src_idle_pct = 69;
    snk_idle_pct <= 16;
    random_traffic(PhaseBytes);
    drain();

    // No idling; halfway the receiver holds off so the decoder backs up.
    src_idle_pct = 0;
    snk_idle_pct <= 0;
    random_traffic(PhaseBytes / 2);
    holdoff_req <= holdoff_req + 1;
    random_traffic(PhaseBytes / 2);
    drain();
    repeat (TailCycles) @(posedge clk_i);

    $display("%0d bytes in, %0d samples compared, %0d block starts (%0d cut table loads)",
             bytes_taken, samples_checked, block_starts, cut_loads);
    $display("%0d mismatching samples", mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
